// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the frame checker blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Types, codes and helpers shared by the IPv4/UDP frame checker modules.
// ----------------------------------------------------------------------------
package ufc_pkg;

    localparam int LEN_FIELD_W   = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;
    localparam int QUEUE_CW      = 2;

    localparam logic [7:0]  UDP_PROTO     = 8'd17;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [15:0] IP_HDR_MIN    = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] CKSUM_GOOD    = 16'hffff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_IP_SHORT  = 3'd1,
        ST_NOT_UDP   = 3'd2,
        ST_UDP_SHORT = 3'd3,
        ST_UDP_LONG  = 3'd4,
        ST_BAD_CKSUM = 3'd5
    } status_t;

    // Everything the back end needs to judge one finished frame.
    typedef struct packed {
        logic [LEN_FIELD_W-1:0] frame_len;
        logic [3:0]             header_words;
        logic [7:0]             protocol;
        logic [19:0]            pseudo_sum;
        logic [15:0]            udp_length;
        logic [15:0]            udp_check;
        logic [31:0]            segment_sum;
        logic [31:0]            port_bytes;
    } frame_rec_t;

    // Odd positions fill the low byte of a 16-bit word, even ones the high byte.
    function automatic logic [15:0] place_byte(input logic odd, input logic [7:0] b);
        place_byte = odd ? {8'h00, b} : {b, 8'h00};
    endfunction

endpackage

// File: design/ipv4_udp_frame_checker.sv
// ----------------------------------------------------------------------------
// ipv4_udp_frame_checker
// IPv4/UDP frame checker: header checks and UDP checksum, one status a frame.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// s_      | in  | s_tvalid / s_tready    | s_tdata = data_byte, s_tlast = last_byte
// m_      | out | m_tvalid / m_tready    | m_tdata[2:0] = status
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_data = skip_checksum
//
// One byte is taken each cycle while the record queue has room; the byte adder
// in the front end sets that rate. A frame's status passes the queue, then a
// four-register back-end pipeline: checks, sum, fold, status.
// Reset is synchronous and active low; no clearing pass is needed.
// s_tready drops only while the two-entry record queue is full; a stalled
// m_ side holds the pipeline and then the queue, never a byte in flight.
// ----------------------------------------------------------------------------
module ipv4_udp_frame_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] status, [7:3] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import ufc_pkg::*;

    logic       skip_reg;
    logic       q_full, q_push, q_valid, q_pop;
    frame_rec_t push_rec, head_rec;
    logic [2:0] status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            skip_reg <= cfg_data;
        end
    end

    ufc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (q_full),
        .rec_push   (q_push),
        .rec_data   (push_rec)
    );

    ufc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (push_rec),
        .full       (q_full),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head_data  (head_rec)
    );

    logic b_ready;
    assign q_pop = q_valid && b_ready;

    ufc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .skip_checksum (skip_reg),
        .rec_valid     (q_valid),
        .rec_ready     (b_ready),
        .rec_data      (head_rec),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (status)
    );

    assign m_tdata = {5'b00000, status};

endmodule

// File: design/ufc_front.sv
// ----------------------------------------------------------------------------
// ufc_front
// Byte-rate front end: captures header fields, accumulates checksum sums
// and hands one frame record to the queue on the final byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ufc_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                queue_full,
    output logic                rec_push,
    output ufc_pkg::frame_rec_t rec_data
);
    import ufc_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [3:0]             hw_reg, hw_next;
    logic [7:0]             proto_reg, proto_next;
    logic [19:0]            pseudo_reg, pseudo_next;
    logic [15:0]            ulen_reg, ulen_next;
    logic [15:0]            uchk_reg, uchk_next;
    logic [31:0]            seg_reg, seg_next;
    logic [31:0]            port_reg, port_next;

    logic                   accept;
    logic [LENGTH_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] hbytes;
    logic [LENGTH_BITS-1:0] q;
    logic                   in_udp;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign pos      = count_reg;

    always_comb begin
        count_next  = (pos == LEN_MAX) ? pos : pos + LENGTH_BITS'(1);
        hw_next     = (pos == '0) ? in_byte[3:0] : hw_reg;
        proto_next  = (pos == LENGTH_BITS'(9)) ? in_byte : proto_reg;
        pseudo_next = pseudo_reg;
        if (pos >= LENGTH_BITS'(12) && pos < LENGTH_BITS'(20)) begin
            pseudo_next = pseudo_reg + 20'(place_byte(pos[0], in_byte));
        end

        // Offset into the UDP segment uses the header length known this byte.
        hbytes    = LENGTH_BITS'({hw_next, 2'b00});
        in_udp    = (pos >= hbytes);
        q         = pos - hbytes;
        port_next = port_reg;
        ulen_next = ulen_reg;
        uchk_next = uchk_reg;
        seg_next  = seg_reg;
        if (in_udp) begin
            if (q < LENGTH_BITS'(4)) begin
                case (q[1:0])
                    2'd0:    port_next[31:24] = in_byte;
                    2'd1:    port_next[23:16] = in_byte;
                    2'd2:    port_next[15:8]  = in_byte;
                    default: port_next[7:0]   = in_byte;
                endcase
            end
            if (q == LENGTH_BITS'(4)) ulen_next[15:8] = in_byte;
            if (q == LENGTH_BITS'(5)) ulen_next[7:0]  = in_byte;
            if (q == LENGTH_BITS'(6)) uchk_next[15:8] = in_byte;
            if (q == LENGTH_BITS'(7)) uchk_next[7:0]  = in_byte;
            // Sum only the declared segment length.
            if (q >= LENGTH_BITS'(6) && 16'(q) < ulen_reg) begin
                seg_next = seg_reg + 32'(place_byte(q[0], in_byte));
            end
        end
    end

    always_comb begin
        rec_push              = accept && in_last;
        rec_data.frame_len    = LEN_FIELD_W'(count_next);
        rec_data.header_words = hw_next;
        rec_data.protocol     = proto_next;
        rec_data.pseudo_sum   = pseudo_next;
        rec_data.udp_length   = ulen_next;
        rec_data.udp_check    = uchk_next;
        rec_data.segment_sum  = seg_next;
        rec_data.port_bytes   = port_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_last)) begin
            count_reg  <= '0;
            hw_reg     <= '0;
            proto_reg  <= '0;
            pseudo_reg <= '0;
            ulen_reg   <= '0;
            uchk_reg   <= '0;
            seg_reg    <= '0;
            port_reg   <= '0;
        end else if (accept) begin
            count_reg  <= count_next;
            hw_reg     <= hw_next;
            proto_reg  <= proto_next;
            pseudo_reg <= pseudo_next;
            ulen_reg   <= ulen_next;
            uchk_reg   <= uchk_next;
            seg_reg    <= seg_next;
            port_reg   <= port_next;
        end
    end

    `AST_NEXT(a_clear_after_last, aclk, aresetn, accept && in_last, count_reg == '0)
    `AST_NEXT(a_count_advances, aclk, aresetn,
        accept && !in_last && (count_reg != LEN_MAX),
        count_reg == $past(count_reg) + LENGTH_BITS'(1))

endmodule

// File: design/ufc_queue.sv
// ----------------------------------------------------------------------------
// ufc_queue
// Two-entry record queue between front end and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ufc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ufc_pkg::frame_rec_t push_data,
    output logic                full,
    output logic                head_valid,
    input  logic                pop,
    output ufc_pkg::frame_rec_t head_data
);
    import ufc_pkg::*;

    frame_rec_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) count_next = count_reg + QUEUE_CW'(1);
        if (!push && do_pop) count_next = count_reg - QUEUE_CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)   wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    `AST_IMPLY(a_no_overflow, aclk, aresetn, push, !full || do_pop)

endmodule

// File: design/ufc_back.sv
// ----------------------------------------------------------------------------
// ufc_back
// Pipelined back end: range checks, checksum total and fold, status out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ufc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                skip_checksum,
    input  logic                rec_valid,
    output logic                rec_ready,
    input  ufc_pkg::frame_rec_t rec_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          out_status
);
    import ufc_pkg::*;

    // stage 1: checks and partial sums
    logic        v1_reg;
    status_t     st1_status_reg;
    logic        st1_ck_reg;
    logic [33:0] st1_sum_a_reg;
    logic [17:0] st1_sum_b_reg;
    // stage 2: full sum
    logic        v2_reg;
    status_t     st2_status_reg;
    logic        st2_ck_reg;
    logic [33:0] st2_sum_reg;
    // stage 3: partly folded sum
    logic        v3_reg;
    status_t     st3_status_reg;
    logic        st3_ck_reg;
    logic [16:0] st3_fold_reg;
    // output register
    logic        ov_reg;
    status_t     out_status_reg;

    logic        load_o, free3, free2, free1;
    status_t     status_next;
    logic        ck_next;
    logic [15:0] len, hbytes, rem, ulen;
    logic [33:0] sum_a_next;
    logic [17:0] sum_b_next;
    logic [18:0] fold1;
    logic [16:0] fold2_next;
    logic [15:0] fold3;
    status_t     final_next;

    assign load_o = !ov_reg || out_ready;
    assign free3  = !v3_reg || load_o;
    assign free2  = !v2_reg || free3;
    assign free1  = !v1_reg || free2;
    assign rec_ready = free1;

    always_comb begin
        len    = rec_data.frame_len;
        ulen   = rec_data.udp_length;
        hbytes = 16'({rec_data.header_words, 2'b00});
        rem    = len - hbytes;
        ck_next = 1'b0;
        if (len < IP_HDR_MIN) begin
            status_next = ST_IP_SHORT;
        end else if (rec_data.protocol != UDP_PROTO) begin
            status_next = ST_NOT_UDP;
        end else if (rec_data.header_words < MIN_IHL || len < hbytes) begin
            status_next = ST_IP_SHORT;
        end else if (rem < UDP_HDR_BYTES) begin
            status_next = ST_UDP_SHORT;
        end else if (ulen > rem) begin
            status_next = ST_UDP_LONG;
        end else begin
            status_next = ST_OK;
            ck_next = !skip_checksum && (rec_data.udp_check != '0) &&
                      (rec_data.header_words == MIN_IHL);
        end

        sum_a_next = 34'(rec_data.pseudo_sum) + 34'(UDP_PROTO) + 34'(ulen)
                   + 34'(rec_data.segment_sum);
        // Port and length bytes count only inside the declared length.
        sum_b_next = '0;
        if (ulen > 16'd0) sum_b_next = sum_b_next + 18'(place_byte(1'b0, rec_data.port_bytes[31:24]));
        if (ulen > 16'd1) sum_b_next = sum_b_next + 18'(place_byte(1'b1, rec_data.port_bytes[23:16]));
        if (ulen > 16'd2) sum_b_next = sum_b_next + 18'(place_byte(1'b0, rec_data.port_bytes[15:8]));
        if (ulen > 16'd3) sum_b_next = sum_b_next + 18'(place_byte(1'b1, rec_data.port_bytes[7:0]));
        if (ulen > 16'd4) sum_b_next = sum_b_next + 18'(place_byte(1'b0, ulen[15:8]));
        if (ulen > 16'd5) sum_b_next = sum_b_next + 18'(place_byte(1'b1, ulen[7:0]));
    end

    always_comb begin
        fold1      = 19'(st2_sum_reg[15:0]) + 19'(st2_sum_reg[33:16]);
        fold2_next = 17'(fold1[15:0]) + 17'(fold1[18:16]);
        fold3      = st3_fold_reg[15:0] + 16'(st3_fold_reg[16]);
        final_next = (st3_ck_reg && fold3 != CKSUM_GOOD) ? ST_BAD_CKSUM : st3_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (free1 && rec_valid) begin
            st1_status_reg <= status_next;
            st1_ck_reg     <= ck_next;
            st1_sum_a_reg  <= sum_a_next;
            st1_sum_b_reg  <= sum_b_next;
        end
        if (free2 && v1_reg) begin
            st2_status_reg <= st1_status_reg;
            st2_ck_reg     <= st1_ck_reg;
            st2_sum_reg    <= st1_sum_a_reg + 34'(st1_sum_b_reg);
        end
        if (free3 && v2_reg) begin
            st3_status_reg <= st2_status_reg;
            st3_ck_reg     <= st2_ck_reg;
            st3_fold_reg   <= fold2_next;
        end
        if (load_o && v3_reg) begin
            out_status_reg <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (free1)  v1_reg <= rec_valid;
            if (free2)  v2_reg <= v1_reg;
            if (free3)  v3_reg <= v2_reg;
            if (load_o) ov_reg <= v3_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = out_status_reg;

    `AST_NEXT(a_stage1_holds, aclk, aresetn, v1_reg && !free2,
        v1_reg && $stable(st1_status_reg) && $stable(st1_sum_a_reg))
    `AST_IMPLY(a_only_ok_checked, aclk, aresetn, v1_reg && st1_ck_reg,
        st1_status_reg == ST_OK)

endmodule

// File: tb/sv/tb_ipv4_udp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_udp_frame_checker
// Streams IPv4 frames byte by byte into the checker and compares each status
// item with a cycle-free prediction of the header checks and the UDP
// checksum, or with the fixed status of a directed row. A table of directed
// frames comes first. Random frames follow, mostly well formed with random
// content and some broken or pure noise. Both sides idle at random, with one
// long output stall and the skip_checksum register toggled between bursts.
// ----------------------------------------------------------------------------
module tb_ipv4_udp_frame_checker;
    import ufc_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_STALL    = 1500;

    typedef enum logic [1:0] {
        CK_GOOD,
        CK_ZERO,
        CK_BAD
    } ck_mode_t;

    // One frame to build: raw frames get random bytes and no header fields.
    typedef struct packed {
        logic        raw;
        logic [16:0] len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] udp_len;
        ck_mode_t    ck;
    } frame_plan_t;

    typedef struct packed {
        frame_plan_t plan;
        logic        skip;
        logic        fixed;
        status_t     st;
    } table_row_t;

    typedef struct packed {
        logic    fixed;
        status_t st;
    } verdict_t;

    localparam table_row_t DIRECTED [21] = '{
        '{'{1'b0, 17'd1,     4'd5,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_IP_SHORT},
        '{'{1'b0, 17'd19,    4'd5,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_IP_SHORT},
        '{'{1'b0, 17'd28,    4'd5,  8'd6,  16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_NOT_UDP},
        '{'{1'b0, 17'd40,    4'd4,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_IP_SHORT},
        '{'{1'b0, 17'd30,    4'd0,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_IP_SHORT},
        '{'{1'b0, 17'd50,    4'd15, 8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_IP_SHORT},
        '{'{1'b0, 17'd27,    4'd5,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_UDP_SHORT},
        '{'{1'b0, 17'd28,    4'd5,  8'd17, 16'd8,      CK_ZERO}, 1'b0, 1'b1, ST_OK},
        '{'{1'b0, 17'd28,    4'd5,  8'd17, 16'd9,      CK_ZERO}, 1'b0, 1'b1, ST_UDP_LONG},
        '{'{1'b0, 17'd40,    4'd5,  8'd17, 16'hffff,   CK_ZERO}, 1'b0, 1'b1, ST_UDP_LONG},
        '{'{1'b0, 17'd60,    4'd5,  8'd17, 16'd40,     CK_GOOD}, 1'b0, 1'b0, ST_OK},
        '{'{1'b0, 17'd61,    4'd5,  8'd17, 16'd41,     CK_GOOD}, 1'b0, 1'b0, ST_OK},
        '{'{1'b0, 17'd80,    4'd5,  8'd17, 16'd30,     CK_GOOD}, 1'b0, 1'b0, ST_OK},
        '{'{1'b0, 17'd50,    4'd5,  8'd17, 16'd30,     CK_BAD},  1'b0, 1'b1, ST_BAD_CKSUM},
        '{'{1'b0, 17'd40,    4'd5,  8'd17, 16'd4,      CK_BAD},  1'b0, 1'b0, ST_OK},
        '{'{1'b0, 17'd40,    4'd5,  8'd17, 16'd0,      CK_BAD},  1'b0, 1'b0, ST_OK},
        '{'{1'b0, 17'd60,    4'd6,  8'd17, 16'd20,     CK_BAD},  1'b0, 1'b1, ST_OK},
        '{'{1'b0, 17'd80,    4'd15, 8'd17, 16'd16,     CK_BAD},  1'b0, 1'b1, ST_OK},
        '{'{1'b0, 17'd50,    4'd5,  8'd17, 16'd30,     CK_BAD},  1'b1, 1'b1, ST_OK},
        '{'{1'b0, 17'd61,    4'd5,  8'd17, 16'd41,     CK_GOOD}, 1'b1, 1'b0, ST_OK},
        '{'{1'b1, 17'd24,    4'd0,  8'd0,  16'd0,      CK_ZERO}, 1'b1, 1'b0, ST_OK}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Frame state of the prediction
    logic [15:0] fr_count   = '0;
    logic [3:0]  fr_ihl     = '0;
    logic [7:0]  fr_proto   = '0;
    logic [19:0] fr_pseudo  = '0;
    logic [15:0] fr_udp_len = '0;
    logic [15:0] fr_udp_ck  = '0;
    logic [31:0] fr_seg_sum = '0;
    logic [31:0] fr_ports   = '0;
    logic        skip_cksum = 1'b0;

    status_t  expected_status [$];
    verdict_t row_verdicts [$];
    int       mismatches   = 0;
    bit       idle_on      = 1'b1;
    bit       rx_stall_req = 1'b0;

    ipv4_udp_frame_checker #(
        .LENGTH_BITS(16)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] lane_align(input int unsigned pos, input logic [7:0] b);
        return pos[0] ? {8'h00, b} : {b, 8'h00};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Fold pseudo-header, UDP header bytes and segment sum; all ones is good.
    function automatic bit udp_sum_ok();
        logic [63:0] acc;
        logic [7:0]  b;
        acc = fr_pseudo + UDP_PROTO + fr_udp_len + fr_seg_sum;
        for (int k = 0; k < 6; k++) begin
            if (k < 4)
                b = fr_ports[8 * (3 - k) +: 8];
            else if (k == 4)
                b = fr_udp_len[15:8];
            else
                b = fr_udp_len[7:0];
            if (k < fr_udp_len)
                acc += lane_align(k, b);
        end
        while (acc[63:16] != 0)
            acc = acc[15:0] + acc[63:16];
        return acc[15:0] == CKSUM_GOOD;
    endfunction

    // Advance the frame state by one byte; on the last byte give the status.
    function automatic bit advance_frame(input logic [7:0] b, input logic last,
                                         output status_t st);
        int unsigned p, hb, q, len;
        st = ST_OK;
        p = fr_count;
        if (fr_count != 16'hffff)
            fr_count++;
        if (p == 0)
            fr_ihl = b[3:0];
        if (p == 9)
            fr_proto = b;
        if (p >= 12 && p < 20)
            fr_pseudo += lane_align(p, b);
        hb = 4 * fr_ihl;
        if (p >= hb) begin
            q = p - hb;
            if (q < 4)
                fr_ports[8 * (3 - q) +: 8] = b;
            else if (q == 4)
                fr_udp_len[15:8] = b;
            else if (q == 5)
                fr_udp_len[7:0] = b;
            if (q == 6)
                fr_udp_ck[15:8] = b;
            else if (q == 7)
                fr_udp_ck[7:0] = b;
            if (q >= 6 && q < fr_udp_len)
                fr_seg_sum += lane_align(q, b);
        end
        if (!last)
            return 1'b0;

        len = fr_count;
        if (len < IP_HDR_MIN)
            st = ST_IP_SHORT;
        else if (fr_proto != UDP_PROTO)
            st = ST_NOT_UDP;
        else if (fr_ihl < MIN_IHL || len < hb)
            st = ST_IP_SHORT;
        else if (len - hb < UDP_HDR_BYTES)
            st = ST_UDP_SHORT;
        else if (fr_udp_len > len - hb)
            st = ST_UDP_LONG;
        else if (!skip_cksum && fr_udp_ck != 0 && fr_ihl == MIN_IHL && !udp_sum_ok())
            st = ST_BAD_CKSUM;

        fr_count   = '0;
        fr_ihl     = '0;
        fr_proto   = '0;
        fr_pseudo  = '0;
        fr_udp_len = '0;
        fr_udp_ck  = '0;
        fr_seg_sum = '0;
        fr_ports   = '0;
        return 1'b1;
    endfunction

    function automatic frame_plan_t random_plan();
        frame_plan_t plan;
        int r, rc, hb, pad;
        r  = $urandom_range(99);
        rc = $urandom_range(99);
        plan.raw     = 1'b0;
        plan.ihl     = MIN_IHL;
        plan.proto   = UDP_PROTO;
        plan.udp_len = 16'($urandom_range(40, 8));
        plan.ck      = (rc < 60) ? CK_GOOD : (rc < 75) ? CK_ZERO : CK_BAD;
        pad = ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0;
        if (r >= 55 && r < 65)
            plan.ihl = 4'($urandom_range(9, 6));
        hb = 4 * plan.ihl;
        plan.len = 17'(hb + plan.udp_len + pad);
        if (r >= 65 && r < 75) begin
            // cut a good frame short
            plan.len = 17'($urandom_range(plan.len - 1, 1));
        end else if (r >= 75 && r < 85) begin
            plan.udp_len = 16'($urandom_range(1) ? $urandom_range(15, 0)
                                                 : $urandom_range(16'hffff, 41));
            plan.len = 17'(hb + $urandom_range(40, 8));
        end else if (r >= 85 && r < 92) begin
            plan.ihl   = 4'($urandom_range(15));
            plan.proto = $urandom_range(1) ? UDP_PROTO : 8'($urandom_range(255));
            plan.len   = 17'($urandom_range(70, 1));
        end else if (r >= 92) begin
            plan.raw = 1'b1;
            plan.len = 17'($urandom_range(60, 1));
        end
        return plan;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic send_frame(input frame_plan_t plan, input logic fixed, input status_t st,
                              input bit gaps);
        logic [7:0]  fb [$];
        logic [63:0] acc;
        logic [15:0] good, cks;
        int unsigned hb;
        fb = {};
        for (int i = 0; i < plan.len; i++)
            fb.push_back(8'($urandom_range(255)));
        hb = 4 * plan.ihl;
        if (!plan.raw) begin
            fb[0] = {4'h4, plan.ihl};
            if (plan.len > 9)
                fb[9] = plan.proto;
            if (hb + 4 < plan.len)
                fb[hb + 4] = plan.udp_len[15:8];
            if (hb + 5 < plan.len)
                fb[hb + 5] = plan.udp_len[7:0];
            cks = 16'h0000;
            if (plan.ck != CK_ZERO) begin
                if (hb + 6 < plan.len)
                    fb[hb + 6] = 8'h00;
                if (hb + 7 < plan.len)
                    fb[hb + 7] = 8'h00;
                acc = UDP_PROTO + plan.udp_len;
                for (int i = 12; i < 20 && i < plan.len; i++)
                    acc += lane_align(i, fb[i]);
                for (int i = 0; i < plan.udp_len && hb + i < plan.len; i++)
                    acc += lane_align(i, fb[hb + i]);
                while (acc[63:16] != 0)
                    acc = acc[15:0] + acc[63:16];
                good = ~acc[15:0];
                if (good == 16'h0000)
                    good = 16'hffff;
                cks = good;
                if (plan.ck == CK_BAD) begin
                    cks = good ^ 16'($urandom_range(16'hffff, 1));
                    if (cks == 16'h0000)
                        cks = (good == 16'h0001) ? 16'h0002 : 16'h0001;
                end
            end
            if (hb + 6 < plan.len)
                fb[hb + 6] = cks[15:8];
            if (hb + 7 < plan.len)
                fb[hb + 7] = cks[7:0];
        end
        row_verdicts.push_back('{fixed, st});
        for (int i = 0; i < plan.len; i++)
            push_byte(fb[i], i == plan.len - 1, gaps);
    endtask

    // Hold the input until every status has come, then let the pipe empty.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_skip(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : scoreboard
        status_t  st;
        verdict_t v;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                skip_cksum = cfg_data;
            if (s_tvalid && s_tready) begin
                if (advance_frame(s_tdata, s_tlast, st)) begin
                    v = row_verdicts.pop_front();
                    expected_status.push_back(v.fixed ? v.st : st);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    $error("status: none expected, actual %0d", m_tdata[2:0]);
                    mismatches++;
                end else begin
                    st = expected_status.pop_front();
                    if (m_tdata[2:0] !== st) begin
                        $error("status: expected %0d, actual %0d", st, m_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        $error("m_tdata[7:3]: expected 0, actual %0d", m_tdata[7:3]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : receiver
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_stall_req) begin
                rx_stall_req = 1'b0;
                wait_left = LONG_STALL;
            end
            if (wait_left > 0) begin
                m_tready <= 1'b0;
                wait_left--;
            end else begin
                m_tready <= 1'b1;
                wait_left = idle_on ? pick_gap() : 0;
            end
        end
    end

    initial begin : stimulus
        frame_plan_t plan;
        logic        cur_skip;
        int          seg, frames, bytes_sent;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_skip(1'b0);
        cur_skip = 1'b0;
        bytes_sent = 0;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].skip != cur_skip) begin
                wait_quiet();
                write_skip(DIRECTED[i].skip);
                cur_skip = DIRECTED[i].skip;
            end
            send_frame(DIRECTED[i].plan, DIRECTED[i].fixed, DIRECTED[i].st,
                       DIRECTED[i].plan.len < 1000);
            bytes_sent += DIRECTED[i].plan.len;
        end

        seg = 0;
        frames = 0;
        while (bytes_sent < 1750 || frames < 24) begin
            if (frames % 12 == 0) begin
                wait_quiet();
                write_skip(seg[0] ? 1'b0 : 1'b1);
                // every third burst runs flat out; the first of those also stalls the output
                idle_on = (seg % 3 != 1);
                if (seg == 1)
                    rx_stall_req = 1'b1;
                seg++;
            end
            plan = random_plan();
            send_frame(plan, 1'b0, ST_OK, idle_on);
            frames++;
            bytes_sent += plan.len;
        end

        wait_quiet();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
